[design/threshold_hit_event_detector_defines.svh]
// Assertion macros shared by the checker of the threshold hit event detector.
// No dependencies; included by files that hold concurrent assertions.
`ifndef THRESHOLD_HIT_EVENT_DETECTOR_DEFINES_SVH
`define THRESHOLD_HIT_EVENT_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define THED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define THED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/thed_pkg.sv]
// Shared types and constants of the threshold hit event detector.
// No dependencies; used by every RTL file of the block.
package thed_pkg;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned WINDOW_BITS   = 24;
  localparam int unsigned POS_BITS      = 48;
  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = 48;
  // Result queue depth; must be a power of two and at least 2.
  localparam int unsigned OUTQ_DEPTH    = 4;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 24'd1000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD = 8'd0,
    REG_HOLD      = 8'd1,
    REG_DEAD      = 8'd2,
    REG_START     = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] threshold;
    logic        [WINDOW_BITS-1:0] hold;
    logic        [WINDOW_BITS-1:0] dead;
  } cfg_t;

  typedef struct packed {
    logic                load;
    logic [POS_BITS-1:0] value;
  } start_load_t;

  typedef struct packed {
    logic [POS_BITS-1:0] event_first;
    logic [POS_BITS-1:0] event_stop;
    logic                by_flush;
    logic                last;
  } result_t;

  // Up to two results written into the queue in one cycle, packed from slot 0.
  typedef struct packed {
    logic [1:0]       count;
    result_t [1:0]    res;
  } push_t;

endpackage

[design/thed_stream_if.sv]
// Valid/ready channel interfaces for the sample input and the event output.
// Depends on thed_pkg for field widths.
interface thed_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [thed_pkg::SAMPLE_BITS-1:0] sample;
  logic                                    block_end;

  modport source (output valid, sample, block_end, input ready);
  modport sink   (input valid, sample, block_end, output ready);
endinterface

interface thed_out_if;
  logic                            valid;
  logic                            ready;
  logic [thed_pkg::POS_BITS-1:0]   event_first;
  logic [thed_pkg::POS_BITS-1:0]   event_stop;
  logic                            by_flush;
  logic                            last;

  modport source (output valid, event_first, event_stop, by_flush, last, input ready);
  modport sink   (input valid, event_first, event_stop, by_flush, last, output ready);
endinterface

[design/thed_regs.sv]
// Configuration register file: threshold, hold and dead windows, start index load.
// Depends on thed_pkg.
module thed_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [thed_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [thed_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output thed_pkg::cfg_t                      cfg_o,
  output thed_pkg::start_load_t               start_o
);

  thed_pkg::cfg_t cfg_q, cfg_d;

  // Register decode. A start index write is passed on as a one-cycle load.
  always_comb begin
    cfg_d         = cfg_q;
    start_o.load  = 1'b0;
    start_o.value = cfg_data_i[thed_pkg::POS_BITS-1:0];
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        thed_pkg::REG_THRESHOLD: cfg_d.threshold = signed'(cfg_data_i[15:0]);
        thed_pkg::REG_HOLD:      cfg_d.hold      = cfg_data_i[thed_pkg::WINDOW_BITS-1:0];
        thed_pkg::REG_DEAD:      cfg_d.dead      = cfg_data_i[thed_pkg::WINDOW_BITS-1:0];
        thed_pkg::REG_START:     start_o.load    = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= '0;
      cfg_q.hold      <= thed_pkg::WINDOW_RESET;
      cfg_q.dead      <= thed_pkg::WINDOW_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/thed_core.sv]
// Input register and event evaluation: crossing test, hold/dead windows, expiry check.
// Depends on thed_pkg; feeds thed_outq with up to two results per item.
module thed_core #(
  parameter int unsigned IndexBits = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  thed_pkg::cfg_t                        cfg_i,
  input  thed_pkg::start_load_t                 start_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [thed_pkg::SAMPLE_BITS-1:0] in_sample_i,
  input  logic                                  in_block_end_i,
  input  logic                                  space_i,
  output thed_pkg::push_t                       push_o
);

  localparam int unsigned PosBits = thed_pkg::POS_BITS;
  localparam int unsigned WinBits = thed_pkg::WINDOW_BITS;
  localparam logic [IndexBits-1:0] IdxOne = IndexBits'(1);

  // Input stage.
  logic                                  in_valid_q;
  logic signed [thed_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                                  block_end_q;

  // Event state.
  logic [IndexBits-1:0] idx_q;
  logic                 in_event_q;
  logic [IndexBits-1:0] open_first_q;
  logic [IndexBits-1:0] open_stop_q;

  logic                 advance;
  logic [IndexBits-1:0] nxt;
  logic [IndexBits-1:0] gap;
  logic [IndexBits-1:0] gap_next;
  logic [IndexBits-1:0] hold_ext;
  logic [WinBits:0]     window_sum;
  logic [IndexBits-1:0] window;
  logic                 crossing;
  logic                 hit_extend;
  logic                 hit_restart;
  logic                 hit_open;
  logic                 stop_upd;
  logic                 in_event_mid;
  logic                 emit_flush;
  logic [IndexBits-1:0] first_new;
  logic [IndexBits-1:0] stop_new;
  thed_pkg::result_t    cross_res;
  thed_pkg::result_t    flush_res;

  // The stage moves on only when the queue can take two results.
  assign advance    = in_valid_q && space_i;
  assign in_ready_o = !in_valid_q || space_i;

  // Distance from the last crossing, modulo the index width.
  assign nxt        = idx_q + IdxOne;
  assign gap        = idx_q - open_stop_q + IdxOne;
  assign hold_ext   = IndexBits'(cfg_i.hold);
  assign window_sum = {1'b0, cfg_i.hold} + {1'b0, cfg_i.dead};
  assign window     = IndexBits'(window_sum);

  // Crossing classification.
  assign crossing    = sample_q > cfg_i.threshold;
  assign hit_extend  = crossing && in_event_q && (gap < hold_ext);
  assign hit_restart = crossing && in_event_q && (gap >= window);
  assign hit_open    = crossing && !in_event_q;
  assign stop_upd    = hit_extend || hit_restart || hit_open;

  assign first_new    = (hit_restart || hit_open) ? idx_q : open_first_q;
  assign stop_new     = stop_upd ? nxt : open_stop_q;
  assign in_event_mid = in_event_q || crossing;

  // Expiry is tested at the following index: one past a fresh crossing, else gap + 1.
  assign gap_next   = stop_upd ? IdxOne : gap + IdxOne;
  assign emit_flush = block_end_q && in_event_mid && (gap_next >= window);

  // Result slots, crossing result first.
  always_comb begin
    cross_res.event_first = PosBits'(open_first_q);
    cross_res.event_stop  = PosBits'(open_stop_q);
    cross_res.by_flush    = 1'b0;
    cross_res.last        = !emit_flush;
    flush_res.event_first = PosBits'(first_new);
    flush_res.event_stop  = PosBits'(stop_new);
    flush_res.by_flush    = 1'b1;
    flush_res.last        = 1'b1;

    push_o.count  = 2'd0;
    if (advance) begin
      push_o.count = {hit_restart && emit_flush, hit_restart ^ emit_flush};
    end
    push_o.res[0] = hit_restart ? cross_res : flush_res;
    push_o.res[1] = flush_res;
  end

  // Input stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q    <= in_sample_i;
      block_end_q <= in_block_end_i;
    end
  end

  // Event state update; a start index write loads the running index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      in_event_q   <= 1'b0;
      open_first_q <= '0;
      open_stop_q  <= '0;
    end else begin
      if (start_i.load) begin
        idx_q <= IndexBits'(start_i.value);
      end else if (advance) begin
        idx_q <= nxt;
      end
      if (advance) begin
        open_first_q <= first_new;
        open_stop_q  <= stop_new;
        in_event_q   <= in_event_mid && !emit_flush;
      end
    end
  end

endmodule

[design/thed_outq.sv]
// Result queue: takes up to two results a cycle, hands out one per handshake.
// Depends on thed_pkg.
module thed_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  thed_pkg::push_t   push_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output thed_pkg::result_t out_data_o
);

  localparam int unsigned Depth   = thed_pkg::OUTQ_DEPTH;
  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);

  thed_pkg::result_t    mem_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q;
  logic [PtrBits-1:0]   rd_ptr_q;
  logic [CntBits-1:0]   count_q;
  logic                 pop;

  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];
  // Room for a full pair of results, judged on the registered fill level.
  assign space_o     = count_q <= CntBits'(Depth - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrBits'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PtrBits'(pop);
      count_q  <= count_q + CntBits'(push_i.count) - CntBits'(pop);
    end
  end

  // Storage writes; slot 1 is used only when two results arrive together.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrBits'(1)] <= push_i.res[1];
    end
  end

endmodule

[design/threshold_hit_event_detector.sv]
// Threshold hit event detector: groups above-threshold samples into events.
// Depends on thed_pkg, thed_stream_if, thed_regs, thed_core and thed_outq.
//
// Usage:
//   in_i carries one signed sample and a block_end flag per item. out_o carries
//   one event per item (first index, stop index, by_flush, last); a sample can
//   cause zero, one or two events, and last marks the final one of a sample.
//   The configuration port writes threshold, hold time, dead time and the start
//   index; writing the start index loads the running sample index at once.
//   An event passes through the input register and the result queue before it
//   is offered on out_o; the sample waits while the queue holds over two events.
//   Throughput: one sample per cycle while the queue has room for two events,
//   set by the single evaluation stage between the input register and the
//   result queue; the output port moves one event per cycle unless stalled.
//   When the receiver stalls, events wait in a four-entry queue; once it holds
//   more than two events the registered sample waits and the input stops.
//   Reset clears the queue and the open event, sets the index to zero, the
//   threshold to zero and both windows to 1000 samples.
module threshold_hit_event_detector #(
  parameter int unsigned IndexBits = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [thed_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [thed_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  thed_in_if.sink                             in_i,
  thed_out_if.source                          out_o
);

  thed_pkg::cfg_t        cfg;
  thed_pkg::start_load_t start_load;
  thed_pkg::push_t       push;
  thed_pkg::result_t     out_data;
  logic                  space;
  logic                  in_ready;
  logic                  out_valid;

  thed_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .start_o    (start_load)
  );

  thed_core #(
    .IndexBits (IndexBits)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start_i        (start_load),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_ready),
    .in_sample_i    (in_i.sample),
    .in_block_end_i (in_i.block_end),
    .space_i        (space),
    .push_o         (push)
  );

  thed_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  // Channel wiring.
  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.event_first = out_data.event_first;
  assign out_o.event_stop  = out_data.event_stop;
  assign out_o.by_flush    = out_data.by_flush;
  assign out_o.last        = out_data.last;

endmodule

[design/thed_checker.sv]
// Port-level checks on the event output of the threshold hit event detector.
// Depends on threshold_hit_event_detector_defines.svh and thed_pkg; bound to the top.
`include "threshold_hit_event_detector_defines.svh"

module thed_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [thed_pkg::POS_BITS-1:0] out_first_i,
  input logic [thed_pkg::POS_BITS-1:0] out_stop_i,
  input logic                          out_by_flush_i,
  input logic                          out_last_i
);

  // A stalled event stays offered and unchanged.
  `THED_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_first_i) && $stable(out_stop_i) && $stable(out_by_flush_i) && $stable(out_last_i), "stalled event changed")

  // The expiry event is always the final event of its sample.
  `THED_ASSERT_IMPL(a_flush_last, clk_i, rst_ni, out_valid_i && out_by_flush_i, out_last_i, "expiry event not marked last")

  // The first of a pair is queued together with its expiry event, so it follows at once.
  `THED_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i, out_valid_i && out_by_flush_i, "second event of a pair missing")

endmodule

bind threshold_hit_event_detector thed_checker u_thed_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_first_i    (out_o.event_first),
  .out_stop_i     (out_o.event_stop),
  .out_by_flush_i (out_o.by_flush),
  .out_last_i     (out_o.last)
);

[tb/sv/thed_event_checker.sv]
// Event checker for the threshold hit event detector: predicts the events from
// the accepted samples and register writes, and compares them with the output.
// Depends on thed_pkg for widths, register indexes and the result type.
module thed_event_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [thed_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [thed_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [thed_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                block_end_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [thed_pkg::POS_BITS-1:0]       event_first_i,
  input  logic [thed_pkg::POS_BITS-1:0]       event_stop_i,
  input  logic                                by_flush_i,
  input  logic                                last_i,
  output int                                  failures_o,
  output int                                  outstanding_o,
  output int                                  events_o
);
  import thed_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  // Register copies and the tracked detector state.
  logic signed [SAMPLE_BITS-1:0] thr_level;
  logic [WINDOW_BITS-1:0]        hold_len;
  logic [WINDOW_BITS-1:0]        dead_len;
  logic [POS_BITS-1:0]           cur_index;
  logic                          event_open;
  logic [POS_BITS-1:0]           evt_first;
  logic [POS_BITS-1:0]           evt_stop;

  result_t expected_events[$];
  int      fail_count = 0;
  int      events_seen = 0;

  assign failures_o = fail_count;
  assign events_o   = events_seen;

  // Samples elapsed since the last crossing of the open event, modulo the index width.
  function automatic logic [POS_BITS-1:0] since_hit(input logic [POS_BITS-1:0] at);
    return at - (evt_stop - 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [POS_BITS-1:0]  here;
    logic [POS_BITS-1:0]  after;
    logic [POS_BITS-1:0]  gap;
    logic [WINDOW_BITS:0] span;
    int                   produced;
    result_t              want;
    if (!rst_ni) begin
      thr_level     = '0;
      hold_len      = WINDOW_RESET;
      dead_len      = WINDOW_RESET;
      cur_index     = '0;
      event_open    = 1'b0;
      evt_first     = '0;
      evt_stop      = '0;
      expected_events.delete();
      outstanding_o <= 0;
    end else begin
      // Register writes; the start index also moves the running index.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD: thr_level = cfg_data_i[SAMPLE_BITS-1:0];
          REG_HOLD:      hold_len  = cfg_data_i[WINDOW_BITS-1:0];
          REG_DEAD:      dead_len  = cfg_data_i[WINDOW_BITS-1:0];
          REG_START:     cur_index = cfg_data_i[POS_BITS-1:0];
          default: ;
        endcase
      end

      // Predict the events caused by an accepted sample item.
      if (in_valid_i && in_ready_i) begin
        here     = cur_index;
        after    = cur_index + 1'b1;
        span     = {1'b0, hold_len} + {1'b0, dead_len};
        produced = 0;
        if (sample_i > thr_level) begin
          if (!event_open) begin
            evt_first  = here;
            evt_stop   = after;
            event_open = 1'b1;
          end else begin
            gap = since_hit(here);
            if (gap < hold_len) begin
              evt_stop = after;
            end else if (gap >= span) begin
              // Crossing past both windows: close the old event, open a new one.
              expected_events.push_back('{event_first: evt_first, event_stop: evt_stop,
                                          by_flush: 1'b0, last: 1'b0});
              produced++;
              evt_first = here;
              evt_stop  = after;
            end
          end
        end
        // Block end: close an open event whose windows have run out.
        if (block_end_i && event_open && since_hit(after) >= span) begin
          expected_events.push_back('{event_first: evt_first, event_stop: evt_stop,
                                      by_flush: 1'b1, last: 1'b0});
          produced++;
          event_open = 1'b0;
        end
        cur_index = after;
        if (produced > 0) expected_events[expected_events.size() - 1].last = 1'b1;
      end

      // Compare an accepted event item with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        events_seen++;
        if (expected_events.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] unexpected event: first=%h stop=%h flush=%b last=%b",
                     $time, event_first_i, event_stop_i, by_flush_i, last_i);
        end else begin
          want = expected_events.pop_front();
          if (event_first_i !== want.event_first || event_stop_i !== want.event_stop ||
              by_flush_i !== want.by_flush || last_i !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("[%0t] event mismatch: expected first=%h stop=%h flush=%b last=%b, got first=%h stop=%h flush=%b last=%b",
                       $time, want.event_first, want.event_stop, want.by_flush, want.last,
                       event_first_i, event_stop_i, by_flush_i, last_i);
          end
        end
      end
      outstanding_o <= expected_events.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the threshold hit event detector test: clock, reset, sample stimulus,
// register programming and the verdict. Depends on thed_pkg, thed_stream_if,
// thed_event_checker and the detector itself.
module testbench;
  import thed_pkg::*;

  localparam int unsigned RANDOM_SAMPLES = 1350;
  localparam int unsigned IDLE_PCT       = 13;
  localparam int unsigned DRAIN_LIMIT    = 5000;

  logic                     clk_i  = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  bit quiet        = 1'b0;
  int samples_sent = 0;
  int phases_run   = 0;
  int failures;
  int outstanding;
  int events_checked;

  thed_in_if  in_if();
  thed_out_if out_if();

  threshold_hit_event_detector u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  thed_event_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .sample_i      (in_if.sample),
    .block_end_i   (in_if.block_end),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .event_first_i (out_if.event_first),
    .event_stop_i  (out_if.event_stop),
    .by_flush_i    (out_if.by_flush),
    .last_i        (out_if.last),
    .failures_o    (failures),
    .outstanding_o (outstanding),
    .events_o      (events_checked)
  );

  // Clock with a period of 4.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: stalls at random except during a quiet stretch.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("Timeout waiting for the detector");
    $display("Test completed with failures");
    $finish;
  end

  // Send one sample item, idling first at random, and wait for its acceptance.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic blk_end);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_if.valid     <= 1'b1;
    in_if.sample    <= smp;
    in_if.block_end <= blk_end;
    do @(posedge clk_i); while (!in_if.ready);
    samples_sent++;
  endtask

  // Stop sending and wait until every predicted event has come out.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Program the registers on consecutive cycles, with junk in the unused data
  // bits, followed by a write to an index the block does not decode.
  task automatic write_regs(input logic [SAMPLE_BITS-1:0] thr, input logic [23:0] hold,
                            input logic [23:0] dead, input logic [47:0] start,
                            input bit load_start);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_THRESHOLD;
    cfg_data_i <= {32'($urandom), thr};
    @(posedge clk_i);
    cfg_idx_i  <= REG_HOLD;
    cfg_data_i <= {24'($urandom), hold};
    @(posedge clk_i);
    cfg_idx_i  <= REG_DEAD;
    cfg_data_i <= {24'($urandom), dead};
    @(posedge clk_i);
    if (load_start) begin
      cfg_idx_i  <= REG_START;
      cfg_data_i <= start;
      @(posedge clk_i);
    end
    cfg_idx_i  <= 8'($urandom_range(4, 255));
    cfg_data_i <= {16'($urandom), 32'($urandom)};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    phases_run++;
  endtask

  // Sample that crosses the threshold with the given chance; a tenth are noise.
  function automatic logic [SAMPLE_BITS-1:0] make_sample(input int thr, input int hit_pct);
    int val;
    if ($urandom_range(0, 9) == 0)
      val = int'($urandom_range(0, 65535)) - 32768;
    else if ($urandom_range(0, 99) < hit_pct && thr < 32767)
      val = int'($urandom_range(thr + 32769, 65535)) - 32768;
    else
      val = int'($urandom_range(0, thr + 32768)) - 32768;
    return 16'(val);
  endfunction

  initial begin : stimulus
    int          thr;
    int          len;
    int          hit_pct;
    int          end_pct;
    int          kind;
    int          random_sent;
    int          guard;
    logic [23:0] hold;
    logic [23:0] dead;
    logic [47:0] start;
    bit          load;
    in_if.valid     = 1'b0;
    in_if.sample    = '0;
    in_if.block_end = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: open an event, block end inside the window, extend it.
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b0);

    // Zero windows near the top of the index range: a crossing with block end
    // gives an expiry event, then the index wraps to zero and a crossing restarts.
    settle();
    write_regs(16'sh8000, 24'd0, 24'd0, 48'hFFFF_FFFF_FFFE, 1'b1);
    send_sample(16'sh8001, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8001, 1'b0);
    send_sample(16'sh0005, 1'b0);

    // Widest windows and top threshold: nothing crosses, and only a jump of
    // the start index lets block end close the open event.
    settle();
    write_regs(16'sh7FFF, 24'hFF_FFFF, 24'hFF_FFFF, 48'h0, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    settle();
    write_regs(16'sh7FFF, 24'hFF_FFFF, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_sample(16'sh0000, 1'b1);

    // Short windows: extension, a crossing in the dead window, then a restart.
    settle();
    write_regs(16'sd100, 24'd5, 24'd3, 48'h0, 1'b1);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sd50, 1'b0);
    send_sample(16'sd101, 1'b0);
    repeat (4) send_sample(16'sd0, 1'b0);
    send_sample(16'sd150, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sd0, 1'b1);

    // Random phases, each with its own register setting and crossing density.
    random_sent = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      settle();
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin hold = 24'd0; dead = 24'd0; end
        1: begin hold = 24'hFF_FFFF; dead = 24'hFF_FFFF; end
        2: begin hold = 24'($urandom_range(1, 12)); dead = 24'd0; end
        3: begin hold = 24'd0; dead = 24'($urandom_range(1, 12)); end
        default: begin
          hold = 24'($urandom_range(1, 12));
          dead = 24'($urandom_range(0, 12));
        end
      endcase
      kind = $urandom_range(0, 9);
      if (kind == 0)      thr = -32768;
      else if (kind == 1) thr = 32767;
      else                thr = int'($urandom_range(0, 65535)) - 32768;
      kind = $urandom_range(0, 5);
      load = (kind < 3);
      if (kind == 0)      start = 48'h0 - 48'($urandom_range(1, 60));
      else if (kind == 1) start = {16'($urandom), 32'($urandom)};
      else                start = 48'($urandom_range(0, 1000));
      write_regs(16'(thr), hold, dead, start, load);
      quiet   = (phases_run == 7);
      len     = $urandom_range(40, 120);
      hit_pct = $urandom_range(5, 60);
      end_pct = $urandom_range(2, 40);
      repeat (len) begin
        send_sample(make_sample(thr, hit_pct), $urandom_range(0, 99) < end_pct);
        random_sent++;
      end
      quiet = 1'b0;
    end

    // Drain, then keep the clock running so that any stray event can still show.
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (outstanding != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);

    $display("Sent %0d samples under %0d register settings; %0d events were checked.",
             samples_sent, phases_run, events_checked);
    if (failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      if (outstanding != 0) $display("%0d predicted events never came out", outstanding);
      $display("%0d mismatched or unexpected events", failures);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
